// File: rtl/normalized_histogram_assert.svh
// Assertion macros for the normalized histogram block.
// Included by the top level; no other dependencies.
`ifndef NORMALIZED_HISTOGRAM_ASSERT_SVH
`define NORMALIZED_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define NH_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("normalized_histogram: implication check failed");
`define NH_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("normalized_histogram: next-cycle check failed");
`else
`define NH_ASSERT_IMP(label, ck, rn, ante, cons)
`define NH_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

// File: rtl/nh_pkg.sv
// Shared constants and types of the normalized histogram block.
// No dependencies; used by the front end, the back end and the top level.
`default_nettype none
package nh_pkg;
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned CFG_W        = 16;
    localparam int unsigned CFG_INDEX_W  = 1;
    localparam int unsigned BIN_INDEX_W  = 6;
    localparam int unsigned PROB_W       = 25;
    // Quotient bits produced by the divider: one fraction bit more than Q1.24, for rounding.
    localparam int unsigned RAW_Q_W      = 25;
    localparam int unsigned STEP_W       = 5;
    localparam int unsigned SMOOTH_INV   = 100000;
    localparam int unsigned SMOOTH_W     = 17;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam logic [CFG_W-1:0] LOW_BOUND_RESET = 16'sd0;
    localparam logic [CFG_W-1:0] BIN_SIZE_RESET  = 16'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOW_BOUND = 1'b0,
        CFG_BIN_SIZE  = 1'b1
    } cfg_index_t;
endpackage
`default_nettype wire

// File: rtl/nh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
`default_nettype none
module nh_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: rtl/nh_queue.sv
// Small FIFO between the binning front end and the counting back end.
// No package dependencies.
`default_nettype none
module nh_queue #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  not_empty
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = slots[rd_ptr_reg];
endmodule
`default_nettype wire

// File: rtl/nh_front.sv
// Front end: takes samples in, works out each one's bin with a bit-serial divider and
// hands the bin to the queue. Depends on nh_pkg for field widths.
`default_nettype none
module nh_front #(
    parameter int unsigned BINS  = 32,
    parameter int unsigned BIN_W = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [nh_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                           is_last,
    input  wire logic        [nh_pkg::CFG_W-1:0] low_bound,
    input  wire logic        [nh_pkg::CFG_W-1:0] bin_size,
    input  wire logic                           queue_full,
    output logic                                push,
    output logic             [BIN_W-1:0]        push_bin,
    output logic                                push_last
);
    localparam int unsigned SW = nh_pkg::SAMPLE_W;
    localparam int unsigned WX = SW + BIN_W;
    localparam int unsigned QW = BIN_W + 1;
    localparam int unsigned CW = $clog2(BIN_W + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t  state_reg, state_next;
    logic [WX-1:0] rem_reg, rem_next;
    logic [WX-1:0] div_reg, div_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] step_reg, step_next;
    logic          neg_reg, neg_next;
    logic          last_reg, last_next;
    logic          accept;

    logic [SW:0]      diff;
    logic [SW-1:0]    w_eff;
    logic             ge;
    logic [BIN_W-1:0] bin_c;

    // A finished bin leaves in the same cycle that the next sample may come in.
    assign push   = (state_reg == F_PUSH) && !queue_full;
    assign busy   = !((state_reg == F_IDLE) || push);
    assign accept = start && !busy;

    assign diff  = {sample[SW-1], sample} - {low_bound[SW-1], low_bound};
    assign w_eff = (bin_size == '0) ? SW'(1) : bin_size;
    assign ge    = (rem_reg >= div_reg);

    // The first step tests the top bin edge itself, so a set top quotient bit means the
    // sample lies above the last bin and the remaining bits are not needed.
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        last_next  = last_reg;
        if (accept)
        begin
            rem_next   = WX'(diff[SW-1:0]);
            div_next   = {w_eff, {BIN_W{1'b0}}};
            quo_next   = '0;
            step_next  = '0;
            neg_next   = diff[SW];
            last_next  = is_last;
            state_next = F_DIV;
        end
        else if (push)
        begin
            state_next = F_IDLE;
        end
        else if (state_reg == F_DIV)
        begin
            rem_next  = ge ? (rem_reg - div_reg) : rem_reg;
            div_next  = div_reg >> 1;
            quo_next  = {quo_reg[QW-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == CW'(BIN_W))
            begin
                state_next = F_PUSH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        priority if (neg_reg)
        begin
            bin_c = '0;
        end
        else if (quo_reg[BIN_W])
        begin
            bin_c = BIN_W'(BINS - 1);
        end
        else if (quo_reg[BIN_W-1:0] > BIN_W'(BINS - 1))
        begin
            bin_c = BIN_W'(BINS - 1);
        end
        else
        begin
            bin_c = quo_reg[BIN_W-1:0];
        end
    end

    assign push_bin  = bin_c;
    assign push_last = last_reg;
endmodule
`default_nettype wire

// File: rtl/nh_back.sv
// Back end: bin counters in RAM, sample count and overflow flag, and the emission
// sequencer with its restoring divider. Depends on nh_pkg and nh_ram.
`default_nettype none
module nh_back #(
    parameter int unsigned BINS       = 32,
    parameter int unsigned COUNT_BITS = 20,
    parameter int unsigned BIN_W      = 5
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                queue_valid,
    input  wire logic [BIN_W-1:0]                    queue_bin,
    input  wire logic                                queue_last,
    output logic                                     pop,
    output logic                                     result_strobe,
    output logic      [nh_pkg::BIN_INDEX_W-1:0]      bin_index,
    output logic      [nh_pkg::PROB_W-1:0]           probability,
    output logic                                     last_bin,
    output logic                                     overflow
);
    localparam int unsigned NUM_W = COUNT_BITS + nh_pkg::SMOOTH_W;
    localparam int unsigned QW    = nh_pkg::RAW_Q_W;
    localparam int unsigned SW    = nh_pkg::STEP_W;
    localparam logic [NUM_W-1:0] K_NUM = NUM_W'(nh_pkg::SMOOTH_INV);
    localparam logic [NUM_W-1:0] K_DEN = NUM_W'(nh_pkg::SMOOTH_INV + BINS);

    typedef enum logic [5:0] {
        S_RUN   = 6'b000001,
        S_DRAIN = 6'b000010,
        S_DEN   = 6'b000100,
        S_READ  = 6'b001000,
        S_NUM   = 6'b010000,
        S_DIV   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  dropped_reg, dropped_next;
    logic [BINS-1:0]       written_reg, written_next;
    logic                  b_valid_reg, b_valid_next;
    logic [BIN_W-1:0]      b_bin_reg, b_bin_next;
    logic                  wr_valid_reg;
    logic [BIN_W-1:0]      wr_bin_reg;
    logic [COUNT_BITS-1:0] wr_data_reg;
    logic [BIN_W-1:0]      k_reg, k_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [NUM_W-1:0]      den_reg, den_next;
    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [QW-1:0]         q_reg, q_next;

    logic                        strobe_reg, strobe_next;
    logic [nh_pkg::BIN_INDEX_W-1:0] idx_reg, idx_next;
    logic [nh_pkg::PROB_W-1:0]   prob_reg, prob_next;
    logic                        lastb_reg, lastb_next;
    logic                        ovf_reg, ovf_next;

    logic [BIN_W-1:0]      raddr;
    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] old_count;
    logic [COUNT_BITS-1:0] inc_value;
    logic [COUNT_BITS-1:0] bin_count;
    logic [NUM_W:0]        shifted;
    logic                  ge;
    logic [QW-1:0]         q_new;
    logic [QW:0]           rounded;

    nh_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(BINS)
    ) u_counts (
        .clk  (clk),
        .we   (b_valid_reg),
        .waddr(b_bin_reg),
        .wdata(inc_value),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign pop   = queue_valid && (state_reg == S_RUN);
    assign raddr = (state_reg == S_RUN) ? queue_bin : k_reg;

    // The counter read for an item is taken at the same edge as the previous item's write and
    // returns the old contents, so the last write is forwarded. A bin never written since the
    // last emission reads as zero.
    always_comb
    begin
        if (wr_valid_reg && (wr_bin_reg == b_bin_reg))
        begin
            old_count = wr_data_reg;
        end
        else if (written_reg[b_bin_reg])
        begin
            old_count = rdata;
        end
        else
        begin
            old_count = '0;
        end
        inc_value = old_count + 1'b1;
        bin_count = written_reg[k_reg] ? rdata : '0;
    end

    assign shifted = {rem_reg, 1'b0};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign q_new   = {q_reg[QW-2:0], ge};
    assign rounded = {1'b0, q_new} + (QW + 1)'(1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        written_next = written_reg;
        b_valid_next = 1'b0;
        b_bin_next   = b_bin_reg;
        k_next       = k_reg;
        step_next    = step_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        strobe_next  = 1'b0;
        idx_next     = idx_reg;
        prob_next    = prob_reg;
        lastb_next   = lastb_reg;
        ovf_next     = ovf_reg;

        if (b_valid_reg)
        begin
            written_next[b_bin_reg] = 1'b1;
        end

        unique case (state_reg)
            S_RUN:
            begin
                if (pop)
                begin
                    b_bin_next = queue_bin;
                    if (count_reg == '1)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        b_valid_next = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                    if (queue_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_DEN;
            end
            S_DEN:
            begin
                den_next   = NUM_W'(count_reg) * K_DEN;
                k_next     = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_NUM;
            end
            S_NUM:
            begin
                rem_next   = NUM_W'(bin_count) * K_NUM + NUM_W'(count_reg);
                q_next     = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? NUM_W'(shifted - {1'b0, den_reg}) : NUM_W'(shifted);
                q_next    = q_new;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(QW - 1))
                begin
                    strobe_next = 1'b1;
                    idx_next    = nh_pkg::BIN_INDEX_W'(k_reg);
                    prob_next   = rounded[QW:1];
                    lastb_next  = (k_reg == BIN_W'(BINS - 1));
                    ovf_next    = dropped_reg;
                    if (k_reg == BIN_W'(BINS - 1))
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        written_next = '0;
                        k_next       = '0;
                        state_next   = S_RUN;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_RUN;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            written_reg  <= '0;
            b_valid_reg  <= 1'b0;
            wr_valid_reg <= 1'b0;
            k_reg        <= '0;
            step_reg     <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            written_reg  <= written_next;
            b_valid_reg  <= b_valid_next;
            wr_valid_reg <= b_valid_reg;
            k_reg        <= k_next;
            step_reg     <= step_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_bin_reg   <= b_bin_next;
        wr_bin_reg  <= b_bin_reg;
        wr_data_reg <= inc_value;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        idx_reg     <= idx_next;
        prob_reg    <= prob_next;
        lastb_reg   <= lastb_next;
        ovf_reg     <= ovf_next;
    end

    assign result_strobe = strobe_reg;
    assign bin_index     = idx_reg;
    assign probability   = prob_reg;
    assign last_bin      = lastb_reg;
    assign overflow      = ovf_reg;
endmodule
`default_nettype wire

// File: rtl/normalized_histogram.sv
// A sample marked is_last passes the bin divider, the queue and the emission set-up (drain
// and denominator); then for each bin come a counter read, the numerator, the quotient bits
// of the restoring divider and an output register. A new sample is taken only once the
// bit-serial bin divider has finished the previous one and its bin leaves for the queue;
// during an emission the four-entry queue fills and busy holds further samples off.
// Results cannot stall. Reset clears the counters through valid bits.
`default_nettype none
`include "normalized_histogram_assert.svh"
module normalized_histogram #(
    parameter int unsigned BINS       = 32,
    parameter int unsigned COUNT_BITS = 20
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [nh_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [nh_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [nh_pkg::SAMPLE_W-1:0]    sample,
    input  wire logic                                  is_last,
    output logic                                       result_strobe,
    output logic      [nh_pkg::BIN_INDEX_W-1:0]        bin_index,
    output logic      [nh_pkg::PROB_W-1:0]             probability,
    output logic                                       last_bin,
    output logic                                       overflow
);
    localparam int unsigned BIN_W = $clog2(BINS);
    localparam int unsigned QD_W  = BIN_W + 1;

    logic [nh_pkg::CFG_W-1:0] low_bound_reg;
    logic [nh_pkg::CFG_W-1:0] bin_size_reg;

    logic             push;
    logic [BIN_W-1:0] push_bin;
    logic             push_last;
    logic             queue_full;
    logic             queue_valid;
    logic             pop;
    logic [QD_W-1:0]  pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg <= nh_pkg::LOW_BOUND_RESET;
            bin_size_reg  <= nh_pkg::BIN_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (nh_pkg::cfg_index_t'(cfg_index))
                nh_pkg::CFG_LOW_BOUND: low_bound_reg <= cfg_data;
                nh_pkg::CFG_BIN_SIZE:  bin_size_reg  <= cfg_data;
                default:               bin_size_reg  <= bin_size_reg;
            endcase
        end
    end

    nh_front #(
        .BINS (BINS),
        .BIN_W(BIN_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .is_last   (is_last),
        .low_bound (low_bound_reg),
        .bin_size  (bin_size_reg),
        .queue_full(queue_full),
        .push      (push),
        .push_bin  (push_bin),
        .push_last (push_last)
    );

    nh_queue #(
        .WIDTH(QD_W),
        .DEPTH(nh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data({push_bin, push_last}),
        .full     (queue_full),
        .pop      (pop),
        .pop_data (pop_data),
        .not_empty(queue_valid)
    );

    nh_back #(
        .BINS      (BINS),
        .COUNT_BITS(COUNT_BITS),
        .BIN_W     (BIN_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_valid  (queue_valid),
        .queue_bin    (pop_data[QD_W-1:1]),
        .queue_last   (pop_data[0]),
        .pop          (pop),
        .result_strobe(result_strobe),
        .bin_index    (bin_index),
        .probability  (probability),
        .last_bin     (last_bin),
        .overflow     (overflow)
    );

    // Bin results are spaced by a full divide, so two strobes never touch.
    `NH_ASSERT_NXT(a_strobe_spaced, clk, rst_n, result_strobe, !result_strobe)
    `NH_ASSERT_IMP(a_prob_range, clk, rst_n, result_strobe, probability <= 25'd16777216)
    `NH_ASSERT_IMP(a_index_range, clk, rst_n, result_strobe, bin_index <= 6'(BINS - 1))
    `NH_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !queue_full || pop)
endmodule
`default_nettype wire
